>>> src/msfr_pkg.sv
// Shared types, constants and the control store of the speed factor regulator.
`timescale 1ns / 1ps
package msfr_pkg;

  // Field widths
  localparam int unsigned PeriodW = 16;
  localparam int unsigned SampleW = 12;
  localparam int unsigned FactorW = 11;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned TargetW = 12;

  // Stream data widths, whole bytes
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 56;

  // Ring depths
  localparam int unsigned RpmTapsDef      = 4;
  localparam int unsigned SetpointTapsDef = 8;
  localparam int unsigned MaxTaps         = 16;

  // Divider sizes: the dividend holds the rpm scale, the quotient a full rpm value
  localparam int unsigned DivNumW = RpmW;
  localparam int unsigned DivDenW = PeriodW;

  // Ring means: sum times a rounded-up reciprocal, exact for sums below 2^SumW
  localparam int unsigned SumW      = RpmW + $clog2(MaxTaps);
  localparam int unsigned MeanShift = SumW + $clog2(MaxTaps);

  // Regulator constants
  localparam int unsigned RpmScaleVal  = 40000;
  localparam int unsigned FactorMaxVal = 1024;
  localparam int unsigned UpdateShift  = 3;
  localparam int unsigned UpdateBias   = 8;
  localparam logic [DivNumW-1:0] RpmScale    = DivNumW'(RpmScaleVal);
  localparam logic [FactorW-1:0] FactorMax   = FactorW'(FactorMaxVal);
  localparam logic [FactorW-1:0] FactorReset = FactorW'(128);

  // Item kinds
  localparam logic KindHall = 1'b0;
  localparam logic KindAdc  = 1'b1;

  // Micro-operations driven into the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_DIV_SCALE,
    OP_RPM_STORE,
    OP_AVG_STORE,
    OP_ERR_STORE,
    OP_FACTOR,
    OP_SP_STORE,
    OP_TARGET_STORE,
    OP_EMIT
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_KIND_ADC,
    C_DIV_BUSY,
    C_OUT_BLOCKED
  } cond_e;

  localparam int unsigned PcW = 4;

  // Program addresses that are jump targets
  localparam logic [PcW-1:0] PcWait    = 4'd0;
  localparam logic [PcW-1:0] PcRpmDiv  = 4'd3;
  localparam logic [PcW-1:0] PcAdc     = 4'd8;
  localparam logic [PcW-1:0] PcEmit    = 4'd10;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PcW-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic div_busy;
    logic out_blocked;
  } status_t;

  // Control store: one word per step
  function automatic uword_t ucode_rom(logic [PcW-1:0] pc);
    uword_t uw;
    unique case (pc)
      4'd0:  uw = '{OP_WAIT,         C_NO_INPUT,    PcWait};
      4'd1:  uw = '{OP_NOP,          C_KIND_ADC,    PcAdc};
      4'd2:  uw = '{OP_DIV_SCALE,    C_NEVER,       PcWait};
      4'd3:  uw = '{OP_NOP,          C_DIV_BUSY,    PcRpmDiv};
      4'd4:  uw = '{OP_RPM_STORE,    C_NEVER,       PcWait};
      4'd5:  uw = '{OP_AVG_STORE,    C_NEVER,       PcWait};
      4'd6:  uw = '{OP_ERR_STORE,    C_NEVER,       PcWait};
      4'd7:  uw = '{OP_FACTOR,       C_ALWAYS,      PcEmit};
      4'd8:  uw = '{OP_SP_STORE,     C_NEVER,       PcWait};
      4'd9:  uw = '{OP_TARGET_STORE, C_NEVER,       PcWait};
      4'd10: uw = '{OP_EMIT,         C_OUT_BLOCKED, PcEmit};
      4'd11, 4'd12, 4'd13, 4'd14, 4'd15: begin
        uw = '{OP_NOP, C_ALWAYS, PcWait};
      end
    endcase
    return uw;
  endfunction

endpackage

>>> src/motor_speed_factor_regulator.sv
// Top level of the motor speed factor regulator.
//
//  Channel    Direction  Fields (low bit first)
//  s_axis     in         tdata: hall_period[15:0], adc_sample[27:16]; tuser: kind
//  m_axis     out        tdata: drive_factor[10:0], average_rpm[26:11],
//                               rpm_error[43:27], target_rpm[55:44]
//
// A hall request runs 16 steps of the restoring divider for 40000/period, then stores
// the rpm, mean, error and factor; an ADC request stores the sample and the target.
// Ring means come from a constant reciprocal multiply, so only the rpm division iterates.
// One request is in flight at a time; after the result enters the output register, a
// spare step leads to the wait step, which accepts even while that result is not taken.
// Reset clears the rings, sums and target to zero and sets the factor to 128.
// A stalled output holds the sequencer at its emit step.
`timescale 1ns / 1ps
module motor_speed_factor_regulator #(
  parameter int unsigned RPM_TAPS      = msfr_pkg::RpmTapsDef,
  parameter int unsigned SETPOINT_TAPS = msfr_pkg::SetpointTapsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // hall_period [15:0], adc_sample [27:16], zero [31:28]
  input  logic [msfr_pkg::InTdataW-1:0]   s_axis_tdata,
  // kind: 0 hall, 1 ADC
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // drive_factor [10:0], average_rpm [26:11], rpm_error [43:27], target_rpm [55:44]
  output logic [msfr_pkg::OutTdataW-1:0]  m_axis_tdata
);
  import msfr_pkg::*;

  op_e     op;
  status_t status;

  // Sequence the steps
  msfr_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .op_o     (op)
  );

  // Execute them
  msfr_dpath #(
    .RPM_TAPS      (RPM_TAPS),
    .SETPOINT_TAPS (SETPOINT_TAPS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

>>> src/msfr_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module msfr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [msfr_pkg::DivNumW-1:0]    dividend_i,
  input  logic [msfr_pkg::DivDenW-1:0]    divisor_i,
  output logic                            busy_o,
  output logic [msfr_pkg::DivNumW-1:0]    quotient_o
);
  import msfr_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] num_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, num_q[DivNumW-1]};
  assign diff  = trial - {1'b0, den_q};

  // Count the remaining steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(DivNumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Load operands, then retire one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      if (!diff[DivDenW]) begin
        rem_q <= diff[DivDenW-1:0];
        num_q <= {num_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DivDenW-1:0];
        num_q <= {num_q[DivNumW-2:0], 1'b0};
      end
    end
  end

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = num_q;

endmodule

>>> src/msfr_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
`timescale 1ns / 1ps
module msfr_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msfr_pkg::status_t status_i,
  output msfr_pkg::op_e     op_o
);
  import msfr_pkg::*;

  logic [PcW-1:0] pc_q;
  logic [PcW-1:0] pc_d;
  uword_t         uw;
  logic           take;

  assign uw = ucode_rom(pc_q);

  // Evaluate the jump condition of the current step
  always_comb begin
    unique case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_NO_INPUT:    take = !status_i.in_valid;
      C_KIND_ADC:    take = (status_i.kind == KindAdc);
      C_DIV_BUSY:    take = status_i.div_busy;
      C_OUT_BLOCKED: take = status_i.out_blocked;
      default:       take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + 1'b1;
  end

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign op_o = uw.op;

endmodule

>>> src/msfr_dpath.sv
// Datapath: input latch, rings with running sums, regulator registers, output stage.
`timescale 1ns / 1ps
module msfr_dpath #(
  parameter int unsigned RPM_TAPS      = msfr_pkg::RpmTapsDef,
  parameter int unsigned SETPOINT_TAPS = msfr_pkg::SetpointTapsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  msfr_pkg::op_e                    op_i,
  output msfr_pkg::status_t                status_o,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [msfr_pkg::InTdataW-1:0]    s_axis_tdata,
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [msfr_pkg::OutTdataW-1:0]   m_axis_tdata
);
  import msfr_pkg::*;

  localparam int unsigned RpmSlotW = (RPM_TAPS > 1) ? $clog2(RPM_TAPS) : 1;
  localparam int unsigned SpSlotW  = (SETPOINT_TAPS > 1) ? $clog2(SETPOINT_TAPS) : 1;
  localparam int unsigned RpmSumW  = RpmW + $clog2(RPM_TAPS);
  localparam int unsigned SpSumW   = SampleW + $clog2(SETPOINT_TAPS);
  localparam logic [RpmSlotW-1:0] RpmSlotLast = RpmSlotW'(RPM_TAPS - 1);
  localparam logic [SpSlotW-1:0]  SpSlotLast  = SpSlotW'(SETPOINT_TAPS - 1);
  localparam logic signed [ErrW-1:0] RoundAdj = ErrW'((1 << UpdateShift) - 1);
  localparam logic signed [ErrW-1:0] UpdBias  = ErrW'(UpdateBias);
  localparam logic signed [ErrW:0]   FactorMaxS = (ErrW + 1)'(FactorMaxVal);
  // Rounded-up reciprocals of the tap counts, scaled by 2^MeanShift
  localparam logic [MeanShift:0] RpmRecip = (MeanShift + 1)'(
      ((longint'(1) << MeanShift) + longint'(RPM_TAPS) - longint'(1)) / longint'(RPM_TAPS));
  localparam logic [MeanShift:0] SpRecip  = (MeanShift + 1)'(
      ((longint'(1) << MeanShift) + longint'(SETPOINT_TAPS) - longint'(1))
      / longint'(SETPOINT_TAPS));

  // Latched request
  logic               kind_q;
  logic [PeriodW-1:0] period_q;
  logic [SampleW-1:0] sample_q;
  logic               accept;

  // Rings and their running sums
  logic [RpmW-1:0]     rpm_hist_q [RPM_TAPS];
  logic [RpmSlotW-1:0] rpm_slot_q;
  logic [RpmSumW-1:0]  rpm_sum_q;
  logic [SampleW-1:0]  sp_ring_q [SETPOINT_TAPS];
  logic [SpSlotW-1:0]  sp_slot_q;
  logic [SpSumW-1:0]   sp_sum_q;

  // Regulator state
  logic [TargetW-1:0]     target_q;
  logic [FactorW-1:0]     factor_q;
  logic [FactorW-1:0]     factor_d;
  logic [RpmW-1:0]        avg_q;
  logic signed [ErrW-1:0] err_q;
  logic signed [ErrW-1:0] err_d;
  logic signed [ErrW-1:0] err_adj;
  logic signed [ErrW-1:0] upd;
  logic signed [ErrW:0]   fsum;

  // Output stage
  logic                 out_valid_q;
  logic [OutTdataW-1:0] out_data_q;
  logic                 out_blocked;
  logic                 emit;

  // Divider hookup and ring means
  logic                       div_start;
  logic [DivNumW-1:0]         div_num;
  logic [DivDenW-1:0]         div_den;
  logic                       div_busy;
  logic [DivNumW-1:0]         div_quot;
  logic [RpmW-1:0]            rpm_new;
  logic [RpmW-1:0]            avg_new;
  logic [TargetW-1:0]         target_new;
  logic [RpmSumW+MeanShift:0] rpm_prod;
  logic [SpSumW+MeanShift:0]  sp_prod;

  assign s_axis_tready = (op_i == OP_WAIT);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_blocked   = out_valid_q && !m_axis_tready;
  assign emit          = (op_i == OP_EMIT) && !out_blocked;

  assign status_o = '{in_valid:    s_axis_tvalid,
                      kind:        kind_q,
                      div_busy:    div_busy,
                      out_blocked: out_blocked};

  // Start the rpm division on its step
  assign div_start = (op_i == OP_DIV_SCALE);
  assign div_num   = RpmScale;
  assign div_den   = period_q;

  msfr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // A stopped motor reads as zero RPM
  assign rpm_new = (period_q == '0) ? '0 : div_quot[RpmW-1:0];

  // Ring means by reciprocal multiplication of the registered sums
  assign rpm_prod   = {{(MeanShift + 1){1'b0}}, rpm_sum_q} * {{RpmSumW{1'b0}}, RpmRecip};
  assign sp_prod    = {{(MeanShift + 1){1'b0}}, sp_sum_q} * {{SpSumW{1'b0}}, SpRecip};
  assign avg_new    = rpm_prod[MeanShift +: RpmW];
  assign target_new = sp_prod[MeanShift +: TargetW];

  // Error against the stored average
  assign err_d = $signed({{(ErrW - TargetW){1'b0}}, target_q})
               - $signed({{(ErrW - RpmW){1'b0}}, avg_q});

  // Step the factor by error/8 rounded toward zero plus bias, then clamp
  always_comb begin
    err_adj = err_q[ErrW-1] ? err_q + RoundAdj : err_q;
    upd     = (err_adj >>> UpdateShift) + UpdBias;
    fsum    = $signed({{(ErrW + 1 - FactorW){1'b0}}, factor_q}) + $signed({upd[ErrW-1], upd});
    if (fsum[ErrW]) begin
      factor_d = '0;
    end else if (fsum > FactorMaxS) begin
      factor_d = FactorMax;
    end else begin
      factor_d = fsum[FactorW-1:0];
    end
  end

  // Latch the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KindHall;
    end else if (accept) begin
      kind_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      period_q <= s_axis_tdata[PeriodW-1:0];
      sample_q <= s_axis_tdata[PeriodW+SampleW-1:PeriodW];
    end
  end

  // Rings, sums and regulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RPM_TAPS; i++) begin
        rpm_hist_q[i] <= '0;
      end
      for (int i = 0; i < SETPOINT_TAPS; i++) begin
        sp_ring_q[i] <= '0;
      end
      rpm_slot_q <= '0;
      rpm_sum_q  <= '0;
      sp_slot_q  <= '0;
      sp_sum_q   <= '0;
      target_q   <= '0;
      factor_q   <= FactorReset;
      avg_q      <= '0;
      err_q      <= '0;
    end else begin
      unique case (op_i)
        OP_RPM_STORE: begin
          rpm_hist_q[rpm_slot_q] <= rpm_new;
          rpm_sum_q  <= rpm_sum_q - RpmSumW'(rpm_hist_q[rpm_slot_q]) + RpmSumW'(rpm_new);
          rpm_slot_q <= (rpm_slot_q == RpmSlotLast) ? '0 : rpm_slot_q + 1'b1;
        end
        OP_AVG_STORE: begin
          avg_q <= avg_new;
        end
        OP_ERR_STORE: begin
          err_q <= err_d;
        end
        OP_FACTOR: begin
          factor_q <= factor_d;
        end
        OP_SP_STORE: begin
          sp_ring_q[sp_slot_q] <= sample_q;
          sp_sum_q  <= sp_sum_q - SpSumW'(sp_ring_q[sp_slot_q]) + SpSumW'(sample_q);
          sp_slot_q <= (sp_slot_q == SpSlotLast) ? '0 : sp_slot_q + 1'b1;
        end
        OP_TARGET_STORE: begin
          target_q <= target_new;
        end
        default: begin
          target_q <= target_q;
        end
      endcase
    end
  end

  // Output stage: hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {target_q, err_q, avg_q, factor_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_factor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    factor_q <= FactorMax)
    else $error("drive factor above its limit");

  a_avg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    avg_q <= RpmScale[RpmW-1:0])
    else $error("average rpm above full scale");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpm_slot_q <= RpmSlotLast && sp_slot_q <= SpSlotLast)
    else $error("ring slot out of range");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("result not presented after emit");

endmodule
